// ===== src/ws2812_pixel_serializer_defines.svh =====
// ---------------------------------------------------------------------------
// ws2812_pixel_serializer_defines
// Assertion macros shared by the serializer RTL.
// ---------------------------------------------------------------------------
`ifndef WS2812_PIXEL_SERIALIZER_DEFINES_SVH
`define WS2812_PIXEL_SERIALIZER_DEFINES_SVH

// clocked check, muted during reset
`define WS2_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never hold
`define WS2_ASSERT_NEVER(label, cond, msg) \
  `WS2_ASSERT(label, !(cond), msg)

`endif

// ===== src/ws2_pkg.sv =====
// ---------------------------------------------------------------------------
// ws2_pkg
// Types and constants of the WS2812 pixel serializer.
// ---------------------------------------------------------------------------
package ws2_pkg;

  localparam int PIXELS         = 256;
  localparam int PIXEL_AW       = $clog2(PIXELS);
  localparam int PIXEL_CW       = PIXEL_AW + 1;
  localparam int BITS_PER_PIXEL = 24;
  localparam int BIT_CW         = 5;
  localparam int TICK_W         = 8;
  localparam int LEDS_W         = 9;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 9;
  localparam int Q_DEPTH        = 2;
  localparam int Q_AW           = $clog2(Q_DEPTH);

  // action codes of an input word
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 2'd3;

  localparam logic [LEDS_W-1:0] RST_LED_COUNT  = 9'd200;
  localparam logic [TICK_W-1:0] RST_ONE_HIGH   = 8'd7;
  localparam logic [TICK_W-1:0] RST_ZERO_HIGH  = 8'd2;
  localparam logic [TICK_W-1:0] RST_BIT_PERIOD = 8'd9;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_WRITE,
    OP_START,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] pixel_index;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } in_word_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
  } out_word_t;

  typedef struct packed {
    op_e                         op;
    logic [PIXEL_AW-1:0]         idx;
    logic [BITS_PER_PIXEL-1:0]   grb;
  } cmd_t;

  typedef struct packed {
    logic [LEDS_W-1:0] led_count;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] bit_period;
  } cfg_t;

  typedef struct packed {
    logic                sending;
    logic [PIXEL_AW-1:0] pix_cnt;
    logic [BIT_CW-1:0]   bit_cnt;
    logic [TICK_W-1:0]   tick_cnt;
    logic                res_push;
    logic                res_pin;
    logic                res_busy;
  } back_sts_t;

endpackage

// ===== src/ws2_ram.sv =====
// ---------------------------------------------------------------------------
// ws2_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module ws2_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ws2_front.sv =====
// ---------------------------------------------------------------------------
// ws2_front
// Accepts input words, decodes the action and queues commands for the back.
// ---------------------------------------------------------------------------
module ws2_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  ws2_pkg::in_word_t  in_word_i,
  input  logic               cmd_pop_i,
  output ws2_pkg::cmd_t      cmd_o,
  output logic               cmd_empty_o
);

  ws2_pkg::cmd_t                cmd_new;
  ws2_pkg::cmd_t                q_mem_q [ws2_pkg::Q_DEPTH];
  logic [ws2_pkg::Q_AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [ws2_pkg::Q_AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ws2_pkg::Q_AW:0]       count_q, count_d;
  logic                         do_push, do_pop;

  always_comb begin
    cmd_new.idx = in_word_i.pixel_index;
    cmd_new.grb = {in_word_i.green, in_word_i.red, in_word_i.blue};
    unique case (in_word_i.action)
      ws2_pkg::ACT_TICK:  cmd_new.op = ws2_pkg::OP_TICK;
      ws2_pkg::ACT_WRITE: cmd_new.op = ws2_pkg::OP_WRITE;
      ws2_pkg::ACT_START: cmd_new.op = ws2_pkg::OP_START;
      default:            cmd_new.op = ws2_pkg::OP_NOP;
    endcase
  end

  assign full        = (count_q == (ws2_pkg::Q_AW + 1)'(ws2_pkg::Q_DEPTH));
  assign cmd_empty_o = (count_q == '0);
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && !cmd_empty_o;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (ws2_pkg::Q_AW + 1)'(do_push) - (ws2_pkg::Q_AW + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== src/ws2_back.sv =====
// ---------------------------------------------------------------------------
// ws2_back
// Executes commands: pixel store writes, frame start and per-tick bit timing.
// ---------------------------------------------------------------------------
module ws2_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ws2_pkg::cfg_t         cfg_i,
  input  ws2_pkg::cmd_t         cmd_i,
  input  logic                  cmd_empty_i,
  output logic                  cmd_pop_o,
  input  logic                  pop,
  output logic                  empty,
  output ws2_pkg::out_word_t    out_word_o,
  output ws2_pkg::back_sts_t    sts_o
);

  logic                               sending_q, sending_d;
  logic [ws2_pkg::PIXEL_AW-1:0]       pix_cnt_q, pix_cnt_d;
  logic [ws2_pkg::BIT_CW-1:0]         bit_cnt_q, bit_cnt_d;
  logic [ws2_pkg::TICK_W-1:0]         tick_cnt_q, tick_cnt_d;

  logic [ws2_pkg::BITS_PER_PIXEL-1:0] pix_word;
  logic                               bit_val;
  logic [ws2_pkg::TICK_W-1:0]         high_ticks;
  logic [ws2_pkg::TICK_W:0]           tick_inc;
  logic [ws2_pkg::BIT_CW-1:0]         bit_inc;
  logic [ws2_pkg::PIXEL_CW-1:0]       pix_inc;
  logic [ws2_pkg::PIXEL_CW-1:0]       frame_n;
  logic                               take;
  logic                               ram_we;
  ws2_pkg::out_word_t                 res_word;

  ws2_pkg::out_word_t                 r_mem_q [ws2_pkg::Q_DEPTH];
  logic [ws2_pkg::Q_AW-1:0]           r_wr_q, r_rd_q;
  logic [ws2_pkg::Q_AW:0]             r_cnt_q;
  logic                               res_full, res_pop;

  assign res_full  = (r_cnt_q == (ws2_pkg::Q_AW + 1)'(ws2_pkg::Q_DEPTH));
  assign empty     = (r_cnt_q == '0);
  assign res_pop   = pop && !empty;
  assign take      = !cmd_empty_i && !res_full;
  assign cmd_pop_o = take;

  // read tracks the counter's next value, so data matches pix_cnt_q
  ws2_ram #(
    .WIDTH(ws2_pkg::BITS_PER_PIXEL),
    .DEPTH(ws2_pkg::PIXELS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cmd_i.idx),
    .wdata_i(cmd_i.grb),
    .raddr_i(pix_cnt_d),
    .rdata_o(pix_word)
  );

  always_comb begin
    if (cfg_i.led_count == '0) begin
      frame_n = ws2_pkg::PIXEL_CW'(1);
    end else if (cfg_i.led_count > ws2_pkg::LEDS_W'(ws2_pkg::PIXELS)) begin
      frame_n = ws2_pkg::PIXEL_CW'(ws2_pkg::PIXELS);
    end else begin
      frame_n = ws2_pkg::PIXEL_CW'(cfg_i.led_count);
    end
  end

  assign bit_val    = pix_word[5'(ws2_pkg::BITS_PER_PIXEL - 1) - bit_cnt_q];
  assign high_ticks = bit_val ? cfg_i.one_high : cfg_i.zero_high;
  assign tick_inc   = {1'b0, tick_cnt_q} + 1'b1;
  assign bit_inc    = bit_cnt_q + 1'b1;
  assign pix_inc    = {1'b0, pix_cnt_q} + 1'b1;

  always_comb begin
    sending_d          = sending_q;
    pix_cnt_d          = pix_cnt_q;
    bit_cnt_d          = bit_cnt_q;
    tick_cnt_d         = tick_cnt_q;
    ram_we             = 1'b0;
    res_word.pin_level = 1'b0;
    res_word.busy_res  = sending_q;
    if (take) begin
      unique case (cmd_i.op)
        ws2_pkg::OP_WRITE: begin
          ram_we = !sending_q;
        end
        ws2_pkg::OP_START: begin
          res_word.busy_res = 1'b1;
          if (!sending_q) begin
            sending_d  = 1'b1;
            pix_cnt_d  = '0;
            bit_cnt_d  = '0;
            tick_cnt_d = '0;
          end
        end
        ws2_pkg::OP_TICK: begin
          if (sending_q) begin
            res_word.pin_level = (tick_cnt_q < high_ticks);
            tick_cnt_d         = tick_inc[ws2_pkg::TICK_W-1:0];
            // a zero period also ends the bit after one tick
            if (tick_inc >= {1'b0, cfg_i.bit_period}) begin
              tick_cnt_d = '0;
              if (bit_inc >= ws2_pkg::BIT_CW'(ws2_pkg::BITS_PER_PIXEL)) begin
                bit_cnt_d = '0;
                pix_cnt_d = pix_inc[ws2_pkg::PIXEL_AW-1:0];
                if (pix_inc >= frame_n) begin
                  pix_cnt_d = '0;
                  sending_d = 1'b0;
                end
              end else begin
                bit_cnt_d = bit_inc;
              end
            end
          end
        end
        ws2_pkg::OP_NOP: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q  <= 1'b0;
      pix_cnt_q  <= '0;
      bit_cnt_q  <= '0;
      tick_cnt_q <= '0;
      r_wr_q     <= '0;
      r_rd_q     <= '0;
      r_cnt_q    <= '0;
    end else begin
      sending_q  <= sending_d;
      pix_cnt_q  <= pix_cnt_d;
      bit_cnt_q  <= bit_cnt_d;
      tick_cnt_q <= tick_cnt_d;
      if (take) begin
        r_wr_q <= r_wr_q + 1'b1;
      end
      if (res_pop) begin
        r_rd_q <= r_rd_q + 1'b1;
      end
      r_cnt_q <= r_cnt_q + (ws2_pkg::Q_AW + 1)'(take) - (ws2_pkg::Q_AW + 1)'(res_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      r_mem_q[r_wr_q] <= res_word;
    end
  end

  assign out_word_o = r_mem_q[r_rd_q];

  always_comb begin
    sts_o.sending  = sending_q;
    sts_o.pix_cnt  = pix_cnt_q;
    sts_o.bit_cnt  = bit_cnt_q;
    sts_o.tick_cnt = tick_cnt_q;
    sts_o.res_push = take;
    sts_o.res_pin  = res_word.pin_level;
    sts_o.res_busy = res_word.busy_res;
  end

endmodule

// ===== src/ws2812_pixel_serializer.sv =====
// ---------------------------------------------------------------------------
// ws2812_pixel_serializer
// WS2812 data line serializer with a 256-pixel store and a register port.
// ---------------------------------------------------------------------------
// A word passes through the command queue and then the result queue on its way out.
// Throughput: one word per cycle while the result queue has room, set by the
// execute step that reads the pixel store through its registered read port.
// Reset: queues empty, frame idle, counters zero, registers at their defaults;
// the pixel store is not cleared and needs no clearing pass.
module ws2812_pixel_serializer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  ws2_pkg::in_word_t                  in_word_i,
  output logic                               empty,
  input  logic                               pop,
  output ws2_pkg::out_word_t                 out_word_o,
  input  logic                               cfg_we_i,
  input  logic [ws2_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ws2_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

`include "ws2812_pixel_serializer_defines.svh"

  ws2_pkg::cfg_t      cfg_q;
  ws2_pkg::cmd_t      cmd;
  logic               cmd_empty;
  logic               cmd_pop;
  ws2_pkg::back_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.led_count  <= ws2_pkg::RST_LED_COUNT;
      cfg_q.one_high   <= ws2_pkg::RST_ONE_HIGH;
      cfg_q.zero_high  <= ws2_pkg::RST_ZERO_HIGH;
      cfg_q.bit_period <= ws2_pkg::RST_BIT_PERIOD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ws2_pkg::CFG_LED_COUNT:  cfg_q.led_count  <= cfg_data_i;
        ws2_pkg::CFG_ONE_HIGH:   cfg_q.one_high   <= cfg_data_i[ws2_pkg::TICK_W-1:0];
        ws2_pkg::CFG_ZERO_HIGH:  cfg_q.zero_high  <= cfg_data_i[ws2_pkg::TICK_W-1:0];
        ws2_pkg::CFG_BIT_PERIOD: cfg_q.bit_period <= cfg_data_i[ws2_pkg::TICK_W-1:0];
      endcase
    end
  end

  ws2_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd),
    .cmd_empty_o(cmd_empty)
  );

  ws2_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .pop        (pop),
    .empty      (empty),
    .out_word_o (out_word_o),
    .sts_o      (sts)
  );

  `WS2_ASSERT_NEVER(a_bit_range, sts.bit_cnt >= 5'(ws2_pkg::BITS_PER_PIXEL), "bit counter out of range")
  `WS2_ASSERT(a_idle_clear, !sts.sending |-> (sts.pix_cnt == '0 && sts.bit_cnt == '0 && sts.tick_cnt == '0), "counters not clear while idle")
  `WS2_ASSERT(a_pin_busy, (sts.res_push && sts.res_pin) |-> sts.res_busy, "pin high reported while idle")
  `WS2_ASSERT(a_frame_end, $fell(sts.sending) |-> $past(sts.res_push), "frame ended without an executed word")

endmodule

// ===== dv/ws2812_pixel_serializer_checker.sv =====
// ---------------------------------------------------------------------------
// ws2812_pixel_serializer_checker
// Watches the word, result and register ports of the serializer, predicts
// the pin level and busy flag of every accepted word and compares them in
// order with the result words that leave the block.
// ---------------------------------------------------------------------------
module ws2812_pixel_serializer_checker
  import ws2_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  full_i,
  input  in_word_t              in_word_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  out_word_t             out_word_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted line state
  logic [BITS_PER_PIXEL-1:0] grb_store [PIXELS];
  int unsigned               led_idx;
  int unsigned               bit_idx;
  int unsigned               tick_idx;
  bit                        frame_on;

  logic [LEDS_W-1:0]         led_count;
  logic [TICK_W-1:0]         one_high;
  logic [TICK_W-1:0]         zero_high;
  logic [TICK_W-1:0]         bit_period;

  out_word_t                 due_words [$];
  int                        mismatches = 0;

  // advances the line by one word and returns the result word it gives
  function automatic out_word_t drive_line(in_word_t w);
    out_word_t                 r;
    logic [BITS_PER_PIXEL-1:0] grb;
    logic [TICK_W-1:0]         hi;
    int unsigned               leds;
    r.pin_level = 1'b0;
    r.busy_res  = frame_on;
    case (op_e'(w.action))
      OP_WRITE: begin
        if (!frame_on) grb_store[w.pixel_index] = {w.green, w.red, w.blue};
      end
      OP_START: begin
        if (!frame_on) begin
          frame_on = 1'b1;
          led_idx  = 0;
          bit_idx  = 0;
          tick_idx = 0;
        end
        r.busy_res = 1'b1;
      end
      OP_TICK: begin
        if (frame_on) begin
          grb = grb_store[led_idx];
          hi  = grb[BITS_PER_PIXEL-1-bit_idx] ? one_high : zero_high;
          r.pin_level = (tick_idx < hi);
          tick_idx++;
          if (tick_idx >= bit_period) begin
            tick_idx = 0;
            bit_idx++;
            if (bit_idx >= BITS_PER_PIXEL) begin
              bit_idx = 0;
              led_idx++;
              // zero acts as one pixel, counts beyond the store saturate
              leds = (led_count == 0) ? 1 : (led_count > PIXELS) ? PIXELS : led_count;
              if (led_idx >= leds) begin
                led_idx  = 0;
                frame_on = 1'b0;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      due_words.delete();
      frame_on   = 1'b0;
      led_idx    = 0;
      bit_idx    = 0;
      tick_idx   = 0;
      led_count  = RST_LED_COUNT;
      one_high   = RST_ONE_HIGH;
      zero_high  = RST_ZERO_HIGH;
      bit_period = RST_BIT_PERIOD;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LED_COUNT:  led_count  = cfg_data_i[LEDS_W-1:0];
          CFG_ONE_HIGH:   one_high   = cfg_data_i[TICK_W-1:0];
          CFG_ZERO_HIGH:  zero_high  = cfg_data_i[TICK_W-1:0];
          CFG_BIT_PERIOD: bit_period = cfg_data_i[TICK_W-1:0];
          default: ;
        endcase
      end
      if (push_i && !full_i) due_words.push_back(drive_line(in_word_i));
      if (pop_i && !empty_i) begin
        if (due_words.size() == 0) begin
          $error("unexpected result word: pin_level %0b busy_res %0b",
                 out_word_i.pin_level, out_word_i.busy_res);
          mismatches++;
        end else begin
          want = due_words.pop_front();
          if (out_word_i.pin_level !== want.pin_level) begin
            $error("pin_level: expected %0b, actual %0b",
                   want.pin_level, out_word_i.pin_level);
            mismatches++;
          end
          if (out_word_i.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, actual %0b",
                   want.busy_res, out_word_i.busy_res);
            mismatches++;
          end
        end
      end
      pending_o    <= due_words.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== dv/ws2812_pixel_serializer_tb.sv =====
// ---------------------------------------------------------------------------
// ws2812_pixel_serializer_tb
// Drives pixel writes, frame starts, tick and nop words into the serializer under
// a range of timing registers, with random stalls on both queues, and lets
// the checker compare every result word against its prediction.
// ---------------------------------------------------------------------------
module ws2812_pixel_serializer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ws2_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int PHASE1_WORDS = 550;
  localparam int PHASE2_WORDS = 1000;
  localparam int ITEM_GOAL    = 1350;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  push       = 1'b0;
  logic                  full;
  in_word_t              in_word    = '0;
  logic                  empty;
  logic                  pop        = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int fail_count;
  int pending_words;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count   = 0;

  // stimulus-side view of the frame, used to keep every shown pixel written
  int frame_ticks_left = 0;
  bit pix_written [PIXELS];
  int cur_leds         = int'(RST_LED_COUNT);
  int cur_period       = int'(RST_BIT_PERIOD);
  int sent_words       = 0;

  ws2812_pixel_serializer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  ws2812_pixel_serializer_checker u_pixel_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .in_word_i    (in_word),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_word_i   (out_word),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ws2812_pixel_serializer test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic in_word_t any_word(op_e op);
    in_word_t w;
    w.action      = op;
    w.pixel_index = 8'($urandom_range(255));
    w.green       = 8'($urandom_range(255));
    w.red         = 8'($urandom_range(255));
    w.blue        = 8'($urandom_range(255));
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (full);
    sent_words++;
    // word taken: follow the frame so starts only show written pixels
    case (op_e'(w.action))
      OP_WRITE: begin
        if (frame_ticks_left == 0) pix_written[w.pixel_index] = 1'b1;
      end
      OP_START: begin
        if (frame_ticks_left == 0) begin
          frame_ticks_left = cur_leds * BITS_PER_PIXEL * cur_period;
        end
      end
      OP_TICK: begin
        if (frame_ticks_left > 0) frame_ticks_left--;
      end
      default: ;
    endcase
  endtask

  // registers change only once every result word is back
  task automatic setup_regs(int leds, int one_hi, int zero_hi, int period);
    push <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LED_COUNT;
    cfg_data_i <= CFG_DATA_W'(leds);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ONE_HIGH;
    cfg_data_i <= CFG_DATA_W'(one_hi);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ZERO_HIGH;
    cfg_data_i <= CFG_DATA_W'(zero_hi);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BIT_PERIOD;
    cfg_data_i <= CFG_DATA_W'(period);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    // zero acts as one pixel, counts beyond the store saturate
    cur_leds   = (leds == 0) ? 1 : (leds > PIXELS) ? PIXELS : leds;
    cur_period = period;
  endtask

  task automatic fill_frame_pixels();
    in_word_t w;
    for (int i = 0; i < cur_leds; i++) begin
      if (!pix_written[i]) begin
        w = any_word(OP_WRITE);
        w.pixel_index = i[7:0];
        send_word(w);
      end
    end
  endtask

  // one frame; busy-time writes, starts and nops are mixed in at noise_pct
  task automatic run_frame(int noise_pct);
    in_word_t w;
    send_word(any_word(OP_START));
    while (frame_ticks_left > 0) begin
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(2))
          0:       w = any_word(OP_WRITE);
          1:       w = any_word(OP_START);
          default: w = any_word(OP_NOP);
        endcase
      end else begin
        w = any_word(OP_TICK);
      end
      send_word(w);
    end
  endtask

  task automatic idle_traffic(int count);
    in_word_t w;
    repeat (count) begin
      case ($urandom_range(3))
        0: w = any_word(OP_TICK);
        1: w = any_word(OP_WRITE);
        2: begin
          w = any_word(OP_WRITE);
          w.pixel_index = 8'($urandom_range(cur_leds - 1));
        end
        default: w = any_word(OP_NOP);
      endcase
      send_word(w);
    end
  endtask

  task automatic random_phases(int goal);
    int leds;
    int one_hi;
    int zero_hi;
    int period;
    while (sent_words < goal) begin
      leds    = $urandom_range(2, 1);
      period  = $urandom_range(6, 2);
      // now and then a high count well past the period
      one_hi  = ($urandom_range(4) == 0) ? $urandom_range(255, 1) : $urandom_range(8, 1);
      zero_hi = ($urandom_range(4) == 0) ? $urandom_range(255, 1) : $urandom_range(8, 1);
      setup_regs(leds, one_hi, zero_hi, period);
      fill_frame_pixels();
      repeat ($urandom_range(2, 1)) begin
        idle_traffic($urandom_range(6));
        run_frame(12);
      end
      idle_traffic($urandom_range(4));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 24;
    recv_idle_pct = 85;

    // idle line at reset registers
    send_word(any_word(OP_TICK));
    send_word(any_word(OP_NOP));
    send_word(in_word_t'{action: OP_WRITE, pixel_index: 8'd0,
                         green: 8'hff, red: 8'h00, blue: 8'h5a});
    send_word(in_word_t'{action: OP_WRITE, pixel_index: 8'd255,
                         green: 8'h00, red: 8'hff, blue: 8'hff});
    send_word(in_word_t'{action: OP_WRITE, pixel_index: 8'd128,
                         green: 8'h80, red: 8'h01, blue: 8'h7e});

    // one-pixel frame, one bits high for the whole period
    setup_regs(1, 2, 1, 2);
    send_word(any_word(OP_START));
    send_word(in_word_t'{action: OP_WRITE, pixel_index: 8'd0,
                         green: 8'h00, red: 8'h00, blue: 8'h00});
    send_word(any_word(OP_START));
    send_word(any_word(OP_NOP));
    while (frame_ticks_left > 0) send_word(any_word(OP_TICK));
    send_word(any_word(OP_TICK));
    send_word(any_word(OP_NOP));

    // one bits high throughout, high count far past the period
    setup_regs(1, 255, 1, 10);
    run_frame(5);
    random_phases(PHASE1_WORDS);

    send_idle_pct = 85;
    recv_idle_pct = 24;
    // zero count sends one pixel, zero bits high throughout
    setup_regs(0, 1, 255, 2);
    fill_frame_pixels();
    run_frame(3);
    random_phases(PHASE2_WORDS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phases(ITEM_GOAL);

    push <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_words == 0) begin
      $display("ws2812_pixel_serializer test passed");
    end else begin
      $display("ws2812_pixel_serializer test failed");
    end
    $finish;
  end

endmodule
